### sv/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Types and constants shared by the LRU tile tag cache.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int HANDLE_BITS = 16;
    localparam int Z_BITS      = 5;
    localparam int OP_BITS     = 3;

    localparam int SIZE_BITS   = 6;
    localparam int PCT_BITS    = 7;
    localparam int PROD_BITS   = SIZE_BITS + PCT_BITS;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 6'd32;
    localparam logic [PCT_BITS-1:0]  PCT_RESET  = 7'd20;

    // floor(p / 100) for p < 2**13 as (p * 10486) >> 20
    localparam int                DIV100_SHIFT = 20;
    localparam logic [13:0]       DIV100_MUL   = 14'd10486;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_QUERY  = 3'd2,
        OP_INVAL  = 3'd3,
        OP_WASH   = 3'd4,
        OP_MARK   = 3'd5
    } t_op;

    typedef enum logic {
        CFG_CACHE_SIZE   = 1'b0,
        CFG_WASH_PERCENT = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_W_MUL,
        S_W_THR,
        S_W_SCAN,
        S_EV_CHK,
        S_EV_RD,
        S_EV_OUT,
        S_INS_PREP,
        S_INS_WR,
        S_INS_EMIT
    } t_state;

    typedef struct packed {
        logic [OP_BITS-1:0]            operation;
        logic signed [COORD_BITS-1:0]  tile_x;
        logic signed [COORD_BITS-1:0]  tile_y;
        logic [Z_BITS-1:0]             tile_z;
        logic [HANDLE_BITS-1:0]        tile_handle;
        logic                          insert_dirty;
    } t_in_item;

    typedef struct packed {
        logic                          found;
        logic [HANDLE_BITS-1:0]        out_handle;
        logic signed [COORD_BITS-1:0]  out_x;
        logic signed [COORD_BITS-1:0]  out_y;
        logic [Z_BITS-1:0]             out_z;
        logic                          evicted;
        logic                          victim_dirty;
        logic                          last;
    } t_out_item;

endpackage

### sv/lru_tile_tag_cache_with_wash_core.sv
// ----------------------------------------------------------------------------
// lru_tile_tag_cache_with_wash_core
// Fully associative tile tag cache in MRU order with dirty bits and wash.
// ----------------------------------------------------------------------------
// One item is handled at a time; o_stall stays high until it is done. The
// key and handle stores have a single read port, so every search walks the
// recency order one rank per cycle, and an insert emits its evicted
// entries one at a time before it writes the new entry. Results leave
// through an output register and may wait there while the next item is
// taken. Cache size is capped at ENTRIES; no clearing pass is needed
// after reset.
module lru_tile_tag_cache_with_wash_core #(
    parameter int ENTRIES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ltc_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ltc_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [ltc_pkg::PCT_BITS-1:0] i_cfg_data
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = $clog2(ENTRIES + 1);
    localparam int LW = (RW > ltc_pkg::SIZE_BITS) ? RW : ltc_pkg::SIZE_BITS;
    localparam int CW = ((RW > 8) ? RW : 8) + 2;
    localparam logic [LW-1:0] ENTRIES_L = LW'(ENTRIES);

    ltc_pkg::t_state r_state, n_state;

    logic [ltc_pkg::SIZE_BITS-1:0] r_size;
    logic [ltc_pkg::PCT_BITS-1:0]  r_pct;
    ltc_pkg::t_in_item r_in;

    logic [SW-1:0] r_order [ENTRIES];
    logic [ENTRIES-1:0] r_dirty;
    logic [RW-1:0] r_occ;
    logic [RW-1:0] r_rank;
    logic [RW-1:0] r_cmp_rank;
    logic          r_cmp_valid;
    logic          r_any_ev;

    logic [ltc_pkg::PROD_BITS-1:0] r_prod;
    logic signed [7:0]             r_thr;

    logic [ltc_pkg::COORD_BITS-1:0]  r_mem_x [ENTRIES];
    logic [ltc_pkg::COORD_BITS-1:0]  r_mem_y [ENTRIES];
    logic [ltc_pkg::Z_BITS-1:0]      r_mem_z [ENTRIES];
    logic [ltc_pkg::HANDLE_BITS-1:0] r_mem_h [ENTRIES];
    logic [ltc_pkg::COORD_BITS-1:0]  r_rd_x, r_rd_y;
    logic [ltc_pkg::Z_BITS-1:0]      r_rd_z;
    logic [ltc_pkg::HANDLE_BITS-1:0] r_rd_h;
    logic [SW-1:0]                   r_slot;

    logic              r_ovalid;
    ltc_pkg::t_out_item r_out, n_out;

    logic          out_free, emit, rd_en, match, ev_more, ev_last;
    logic [RW-1:0] rd_rank;
    logic [SW-1:0] rd_slot;
    logic [LW-1:0] limit, occ_l;
    logic [26:0]   wt_full;
    logic [6:0]    wt;
    logic signed [CW-1:0] rank_s, thr_s;
    ltc_pkg::t_op  op;

    assign op          = ltc_pkg::t_op'(r_in.operation);
    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ltc_pkg::S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign out_free    = !r_ovalid || !i_stall;

    assign limit   = (LW'(r_size) > ENTRIES_L) ? ENTRIES_L : LW'(r_size);
    assign occ_l   = LW'(r_occ);
    assign ev_more = (r_occ != '0) && (occ_l >= limit);
    // next eviction would need occ - 1 > 0 and occ > limit
    assign ev_last = (limit != '0) && !((occ_l > LW'(1)) && (occ_l > limit));

    assign rd_slot = r_order[rd_rank[SW-1:0]];
    assign match   = r_cmp_valid && (r_rd_x == r_in.tile_x) && (r_rd_y == r_in.tile_y)
                     && (r_rd_z == r_in.tile_z);

    assign wt_full = 27'(r_prod) * 27'(ltc_pkg::DIV100_MUL);
    assign wt      = wt_full[ltc_pkg::DIV100_SHIFT +: 7];
    assign rank_s  = $signed(CW'(r_rank));
    assign thr_s   = CW'(r_thr);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= ltc_pkg::SIZE_RESET;
            r_pct  <= ltc_pkg::PCT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ltc_pkg::t_cfg_reg'(i_cfg_index))
                ltc_pkg::CFG_CACHE_SIZE:   r_size <= i_cfg_data[ltc_pkg::SIZE_BITS-1:0];
                ltc_pkg::CFG_WASH_PERCENT: r_pct  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_rank = r_rank;
        emit    = 1'b0;
        n_out   = '0;
        n_out.last = 1'b1;
        case (r_state)
            ltc_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (ltc_pkg::t_op'(i_data.operation))
                        ltc_pkg::OP_LOOKUP, ltc_pkg::OP_QUERY, ltc_pkg::OP_INVAL:
                            n_state = (r_size != '0) ? ltc_pkg::S_SCAN : ltc_pkg::S_MISS;
                        ltc_pkg::OP_MARK:   n_state = ltc_pkg::S_SCAN;
                        ltc_pkg::OP_INSERT: n_state = ltc_pkg::S_EV_CHK;
                        ltc_pkg::OP_WASH:   n_state = ltc_pkg::S_W_MUL;
                        default:            n_state = ltc_pkg::S_MISS;
                    endcase
                end
            end
            ltc_pkg::S_SCAN: begin
                // issue rank k while comparing rank k - 1
                if (match) begin
                    n_state = ltc_pkg::S_HIT;
                end else if (r_rank < r_occ) begin
                    rd_en = 1'b1;
                end else if (!r_cmp_valid) begin
                    n_state = ltc_pkg::S_MISS;
                end
            end
            ltc_pkg::S_HIT: begin
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.found        = 1'b1;
                    n_out.out_handle   = r_rd_h;
                    n_out.out_x        = r_rd_x;
                    n_out.out_y        = r_rd_y;
                    n_out.out_z        = r_rd_z;
                    n_out.victim_dirty = (op == ltc_pkg::OP_INVAL) ? r_dirty[r_slot]
                                                                   : (op == ltc_pkg::OP_WASH);
                    n_state            = ltc_pkg::S_IDLE;
                end
            end
            ltc_pkg::S_MISS: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ltc_pkg::S_IDLE;
                end
            end
            ltc_pkg::S_W_MUL: n_state = ltc_pkg::S_W_THR;
            ltc_pkg::S_W_THR: n_state = ltc_pkg::S_W_SCAN;
            ltc_pkg::S_W_SCAN: begin
                // from the LRU end down; ranks at or below the threshold end it
                rd_rank = r_rank - RW'(1);
                if ((r_rank == '0) || !(rank_s > thr_s)) begin
                    n_state = ltc_pkg::S_MISS;
                end else if (r_dirty[rd_slot]) begin
                    rd_en   = 1'b1;
                    n_state = ltc_pkg::S_HIT;
                end
            end
            ltc_pkg::S_EV_CHK: begin
                if (ev_more) begin
                    n_state = ltc_pkg::S_EV_RD;
                end else if (limit == '0) begin
                    n_state = ltc_pkg::S_INS_EMIT;
                end else begin
                    n_state = ltc_pkg::S_INS_PREP;
                end
            end
            ltc_pkg::S_EV_RD: begin
                rd_rank = r_occ - RW'(1);
                rd_en   = 1'b1;
                n_state = ltc_pkg::S_EV_OUT;
            end
            ltc_pkg::S_EV_OUT: begin
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.out_handle   = r_rd_h;
                    n_out.out_x        = r_rd_x;
                    n_out.out_y        = r_rd_y;
                    n_out.out_z        = r_rd_z;
                    n_out.evicted      = 1'b1;
                    n_out.victim_dirty = r_dirty[r_slot];
                    n_out.last         = ev_last;
                    n_state            = ltc_pkg::S_EV_CHK;
                end
            end
            ltc_pkg::S_INS_PREP: begin
                rd_rank = r_occ;
                rd_en   = 1'b1;
                n_state = ltc_pkg::S_INS_WR;
            end
            ltc_pkg::S_INS_WR: begin
                if (r_any_ev || out_free) begin
                    emit    = !r_any_ev;
                    n_state = ltc_pkg::S_IDLE;
                end
            end
            ltc_pkg::S_INS_EMIT: begin
                // size zero: the new entry itself is the last victim
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.out_handle   = r_in.tile_handle;
                    n_out.out_x        = r_in.tile_x;
                    n_out.out_y        = r_in.tile_y;
                    n_out.out_z        = r_in.tile_z;
                    n_out.evicted      = 1'b1;
                    n_out.victim_dirty = r_in.insert_dirty;
                    n_state            = ltc_pkg::S_IDLE;
                end
            end
            default: n_state = ltc_pkg::S_IDLE;
        endcase
    end

    // store read port and insert write
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_x <= r_mem_x[rd_slot];
            r_rd_y <= r_mem_y[rd_slot];
            r_rd_z <= r_mem_z[rd_slot];
            r_rd_h <= r_mem_h[rd_slot];
            r_slot <= rd_slot;
        end
        if ((r_state == ltc_pkg::S_INS_WR) && (n_state == ltc_pkg::S_IDLE)) begin
            r_mem_x[r_slot] <= r_in.tile_x;
            r_mem_y[r_slot] <= r_in.tile_y;
            r_mem_z[r_slot] <= r_in.tile_z;
            r_mem_h[r_slot] <= r_in.tile_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ltc_pkg::S_IDLE && i_valid) begin
            r_in <= i_data;
        end
        if (r_state == ltc_pkg::S_W_MUL) begin
            r_prod <= ltc_pkg::PROD_BITS'(r_pct) * ltc_pkg::PROD_BITS'(r_size);
        end
        if (r_state == ltc_pkg::S_W_THR) begin
            r_thr <= $signed({2'b00, r_size}) - $signed({1'b0, wt});
        end
    end

    // recency order, dirty bits, occupancy, scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_order[i] <= SW'(i);
            end
            r_dirty     <= '0;
            r_occ       <= '0;
            r_rank      <= '0;
            r_cmp_rank  <= '0;
            r_cmp_valid <= 1'b0;
            r_any_ev    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ltc_pkg::S_IDLE: begin
                    r_cmp_valid <= 1'b0;
                    r_any_ev    <= 1'b0;
                    r_rank      <= (ltc_pkg::t_op'(i_data.operation) == ltc_pkg::OP_WASH)
                                   ? r_occ : '0;
                end
                ltc_pkg::S_SCAN: begin
                    if (!match) begin
                        r_cmp_valid <= rd_en;
                    end
                    if (rd_en) begin
                        r_cmp_rank <= r_rank;
                        r_rank     <= r_rank + RW'(1);
                    end
                end
                ltc_pkg::S_W_SCAN: begin
                    if (n_state == ltc_pkg::S_W_SCAN) begin
                        r_rank <= r_rank - RW'(1);
                    end
                end
                ltc_pkg::S_HIT: begin
                    if (emit) begin
                        case (op)
                            ltc_pkg::OP_LOOKUP, ltc_pkg::OP_QUERY: begin
                                for (int i = 1; i < ENTRIES; i++) begin
                                    if (RW'(i) <= r_cmp_rank) r_order[i] <= r_order[i-1];
                                end
                                r_order[0] <= r_slot;
                            end
                            ltc_pkg::OP_INVAL: begin
                                r_dirty[r_slot] <= 1'b0;
                                for (int i = 0; i < ENTRIES; i++) begin
                                    if (i < ENTRIES - 1 && RW'(i) >= r_cmp_rank
                                        && (RW'(i) + RW'(1)) < r_occ) begin
                                        r_order[i] <= r_order[(i + 1) % ENTRIES];
                                    end
                                    if ((RW'(i) + RW'(1)) == r_occ) r_order[i] <= r_slot;
                                end
                                r_occ <= r_occ - RW'(1);
                            end
                            ltc_pkg::OP_WASH: r_dirty[r_slot] <= 1'b0;
                            ltc_pkg::OP_MARK: r_dirty[r_slot] <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                ltc_pkg::S_EV_OUT: begin
                    if (emit) begin
                        r_occ    <= r_occ - RW'(1);
                        r_any_ev <= 1'b1;
                    end
                end
                ltc_pkg::S_INS_WR: begin
                    if (n_state == ltc_pkg::S_IDLE) begin
                        r_dirty[r_slot] <= r_in.insert_dirty;
                        for (int i = 1; i < ENTRIES; i++) begin
                            if (RW'(i) <= r_occ) r_order[i] <= r_order[i-1];
                        end
                        r_order[0] <= r_slot;
                        r_occ      <= r_occ + RW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= RW'(ENTRIES))
        else $error("occupancy above capacity");

    a_evict_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.evicted |-> !o_data.found)
        else $error("evicted item reported as found");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken before first finished");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ltc_pkg::S_IDLE |=> $stable(r_occ))
        else $error("occupancy changed while idle");

endmodule

### tb/sv/tb_lru_tile_tag_cache_with_wash_core.sv
// ----------------------------------------------------------------------------
// tb_lru_tile_tag_cache_with_wash_core
// Self-checking bench for the LRU tile tag cache: a cache predictor tracks
// keys, recency order and dirty bits, and every result item is compared in
// order against it while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_lru_tile_tag_cache_with_wash_core;

    localparam int          SLOTS     = 32;
    localparam int          MAX_CYC   = 600000;
    localparam logic [2:0]  OP_RSVD6  = 3'd6;
    localparam logic [2:0]  OP_RSVD7  = 3'd7;

    class cache_scoreboard;
        logic [15:0] key_x[SLOTS];
        logic [15:0] key_y[SLOTS];
        logic [4:0]  key_z[SLOTS];
        logic [15:0] handle[SLOTS];
        bit          dirty[SLOTS];
        int          order[SLOTS];
        int          occ;
        int          size_reg;
        int          pct_reg;
        ltc_pkg::t_out_item pending_q[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                order[i] = i;
                dirty[i] = 0;
            end
            occ = 0;
            size_reg = 32;
            pct_reg = 20;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(ltc_pkg::t_cfg_reg idx, int value);
            if (idx == ltc_pkg::CFG_CACHE_SIZE) size_reg = value & 63;
            else pct_reg = value & 127;
        endfunction

        function int find_rank(logic [15:0] x, logic [15:0] y, logic [4:0] z);
            for (int r = 0; r < occ; r++)
                if (key_x[order[r]] == x && key_y[order[r]] == y && key_z[order[r]] == z)
                    return r;
            return -1;
        endfunction

        function void to_front(int r);
            int s;
            s = order[r];
            for (int k = r; k > 0; k--) order[k] = order[k-1];
            order[0] = s;
        endfunction

        function ltc_pkg::t_out_item slot_res(int s, bit fnd, bit ev, bit vd);
            ltc_pkg::t_out_item o;
            o = '0;
            o.found = fnd;
            o.out_handle = handle[s];
            o.out_x = key_x[s];
            o.out_y = key_y[s];
            o.out_z = key_z[s];
            o.evicted = ev;
            o.victim_dirty = vd;
            return o;
        endfunction

        // predict the result items of one accepted input item
        function void note_item(ltc_pkg::t_in_item it);
            ltc_pkg::t_out_item res[$];
            ltc_pkg::t_out_item o;
            int r, s, lim, wt, thr, pick;
            case (it.operation)
                ltc_pkg::OP_LOOKUP, ltc_pkg::OP_QUERY: begin
                    r = (size_reg > 0) ? find_rank(it.tile_x, it.tile_y, it.tile_z) : -1;
                    if (r >= 0) begin
                        s = order[r];
                        to_front(r);
                        res.push_back(slot_res(s, 1, 0, 0));
                    end
                end
                ltc_pkg::OP_INSERT: begin
                    lim = (size_reg < SLOTS) ? size_reg : SLOTS;
                    while (occ > 0 && occ + 1 > lim) begin
                        s = order[occ-1];
                        res.push_back(slot_res(s, 0, 1, dirty[s]));
                        occ--;
                    end
                    if (lim == 0) begin
                        // the new entry itself falls out
                        o = '0;
                        o.out_handle = it.tile_handle;
                        o.out_x = it.tile_x;
                        o.out_y = it.tile_y;
                        o.out_z = it.tile_z;
                        o.evicted = 1;
                        o.victim_dirty = it.insert_dirty;
                        res.push_back(o);
                    end else begin
                        s = order[occ];
                        key_x[s] = it.tile_x;
                        key_y[s] = it.tile_y;
                        key_z[s] = it.tile_z;
                        handle[s] = it.tile_handle;
                        dirty[s] = it.insert_dirty;
                        to_front(occ);
                        occ++;
                    end
                end
                ltc_pkg::OP_INVAL: begin
                    r = (size_reg > 0) ? find_rank(it.tile_x, it.tile_y, it.tile_z) : -1;
                    if (r >= 0) begin
                        s = order[r];
                        res.push_back(slot_res(s, 1, 0, dirty[s]));
                        dirty[s] = 0;
                        for (int k = r; k + 1 < occ; k++) order[k] = order[k+1];
                        order[occ-1] = s;
                        occ--;
                    end
                end
                ltc_pkg::OP_WASH: begin
                    wt = (pct_reg * size_reg) / 100;
                    thr = size_reg - wt;
                    pick = -1;
                    for (int k = 0; k < occ; k++)
                        if (dirty[order[k]] && k + 1 > thr) pick = k;
                    if (pick >= 0) begin
                        s = order[pick];
                        dirty[s] = 0;
                        res.push_back(slot_res(s, 1, 0, 1));
                    end
                end
                ltc_pkg::OP_MARK: begin
                    r = find_rank(it.tile_x, it.tile_y, it.tile_z);
                    if (r >= 0) begin
                        s = order[r];
                        dirty[s] = 1;
                        res.push_back(slot_res(s, 1, 0, 0));
                    end
                end
                default: ;
            endcase
            if (res.size() == 0) res.push_back('0);
            o = res[res.size()-1];
            o.last = 1;
            res[res.size()-1] = o;
            foreach (res[i]) pending_q.push_back(res[i]);
        endfunction

        function void check(ltc_pkg::t_out_item got);
            ltc_pkg::t_out_item e;
            checked++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
                return;
            end
            e = pending_q.pop_front();
            if (got.found !== e.found || got.out_handle !== e.out_handle ||
                got.out_x !== e.out_x || got.out_y !== e.out_y ||
                got.out_z !== e.out_z || got.evicted !== e.evicted ||
                got.victim_dirty !== e.victim_dirty || got.last !== e.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp f=%0d h=%h x=%h y=%h z=%0d ev=%0d vd=%0d l=%0d",
                             e.found, e.out_handle, e.out_x, e.out_y, e.out_z,
                             e.evicted, e.victim_dirty, e.last);
                    $display("          got f=%0d h=%h x=%h y=%h z=%0d ev=%0d vd=%0d l=%0d",
                             got.found, got.out_handle, got.out_x, got.out_y, got.out_z,
                             got.evicted, got.victim_dirty, got.last);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    ltc_pkg::t_in_item   i_data;
    logic       o_valid;
    logic       i_stall;
    ltc_pkg::t_out_item  o_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [ltc_pkg::PCT_BITS-1:0] i_cfg_data;

    cache_scoreboard sb;
    bit          calm;
    int          cycles;
    int          items_sent;
    ltc_pkg::t_in_item    key_pool[12];

    lru_tile_tag_cache_with_wash_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        i_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall, check on every accepted item
    always @(negedge i_clk)
        if (i_rst_n) i_stall = !calm && ($urandom_range(99) < 29);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) sb.check(o_data);

    task automatic send_item(ltc_pkg::t_in_item it);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 29) begin
            i_valid = 0;
            repeat ($urandom_range(4)) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_valid = 1;
        i_data = it;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
            @(negedge i_clk);
        end
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_reg(ltc_pkg::t_cfg_reg idx, int value);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = value[ltc_pkg::PCT_BITS-1:0];
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function automatic ltc_pkg::t_in_item mk(logic [2:0] op, ltc_pkg::t_in_item k,
                                             logic [15:0] h, bit d);
        ltc_pkg::t_in_item it;
        it = k;
        it.operation = op;
        it.tile_handle = h;
        it.insert_dirty = d;
        return it;
    endfunction

    function automatic ltc_pkg::t_in_item rand_item();
        ltc_pkg::t_in_item it;
        int p;
        it = key_pool[$urandom_range(11)];
        if ($urandom_range(99) < 15) begin
            it.tile_x = 16'($urandom);
            it.tile_y = 16'($urandom);
            it.tile_z = 5'($urandom);
        end
        it.tile_handle = 16'($urandom);
        it.insert_dirty = 1'($urandom);
        p = $urandom_range(99);
        if (p < 30) it.operation = ltc_pkg::OP_INSERT;
        else if (p < 50) it.operation = ltc_pkg::OP_LOOKUP;
        else if (p < 60) it.operation = ltc_pkg::OP_QUERY;
        else if (p < 72) it.operation = ltc_pkg::OP_INVAL;
        else if (p < 82) it.operation = ltc_pkg::OP_WASH;
        else if (p < 95) it.operation = ltc_pkg::OP_MARK;
        else it.operation = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
        return it;
    endfunction

    initial begin
        int sizes[7];
        int pcts[7];
        ltc_pkg::t_in_item ka, kb;
        sb = new();
        calm = 0;
        cycles = 0;
        items_sent = 0;
        sizes = '{32, 1, 4, 8, 0, 3, 32};
        pcts  = '{20, 0, 100, 50, 127, 75, 20};
        foreach (key_pool[i]) begin
            key_pool[i] = '0;
            key_pool[i].tile_x = 16'($urandom);
            key_pool[i].tile_y = 16'($urandom);
            key_pool[i].tile_z = 5'($urandom);
        end
        key_pool[0].tile_x = 16'h8000; key_pool[0].tile_y = 16'h7fff; key_pool[0].tile_z = 5'd31;
        key_pool[1].tile_x = 16'h7fff; key_pool[1].tile_y = 16'h8000; key_pool[1].tile_z = 5'd0;
        ka = key_pool[0];
        kb = key_pool[1];

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, every operation, duplicates, size zero, wide wash
        send_item(mk(ltc_pkg::OP_INSERT, ka, 16'hffff, 1));
        send_item(mk(ltc_pkg::OP_INSERT, kb, 16'h0000, 0));
        send_item(mk(ltc_pkg::OP_LOOKUP, ka, 0, 0));
        send_item(mk(ltc_pkg::OP_LOOKUP, key_pool[5], 0, 0));
        send_item(mk(ltc_pkg::OP_QUERY, kb, 0, 0));
        send_item(mk(ltc_pkg::OP_MARK, kb, 0, 0));
        send_item(mk(ltc_pkg::OP_MARK, key_pool[6], 0, 0));
        send_item(mk(ltc_pkg::OP_WASH, ka, 0, 0));
        send_item(mk(ltc_pkg::OP_INSERT, ka, 16'h1234, 0));
        send_item(mk(ltc_pkg::OP_LOOKUP, ka, 0, 0));
        send_item(mk(ltc_pkg::OP_INVAL, ka, 0, 0));
        send_item(mk(ltc_pkg::OP_INVAL, key_pool[7], 0, 0));
        send_item(mk(OP_RSVD6, ka, 16'hffff, 1));
        send_item(mk(OP_RSVD7, kb, 16'hffff, 1));
        drain();
        write_reg(ltc_pkg::CFG_CACHE_SIZE, 0);
        send_item(mk(ltc_pkg::OP_LOOKUP, kb, 0, 0));
        send_item(mk(ltc_pkg::OP_MARK, kb, 0, 0));
        send_item(mk(ltc_pkg::OP_INVAL, kb, 0, 0));
        send_item(mk(ltc_pkg::OP_INSERT, key_pool[2], 16'h5a5a, 1));
        drain();
        write_reg(ltc_pkg::CFG_CACHE_SIZE, 2);
        write_reg(ltc_pkg::CFG_WASH_PERCENT, 100);
        send_item(mk(ltc_pkg::OP_INSERT, ka, 16'h00ff, 1));
        send_item(mk(ltc_pkg::OP_INSERT, kb, 16'hff00, 1));
        send_item(mk(ltc_pkg::OP_INSERT, key_pool[3], 16'h0f0f, 0));
        send_item(mk(ltc_pkg::OP_WASH, ka, 0, 0));
        drain();
        write_reg(ltc_pkg::CFG_WASH_PERCENT, 127);
        send_item(mk(ltc_pkg::OP_WASH, ka, 0, 0));

        // random phases over several settings; pause for full drain between
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_reg(ltc_pkg::CFG_CACHE_SIZE, sizes[ph]);
            write_reg(ltc_pkg::CFG_WASH_PERCENT, pcts[ph]);
            calm = (ph == 3);
            repeat (13) send_item(rand_item());
        end
        calm = 0;
        drain();

        $display("%0d input items sent, %0d result items checked, 7 size/percent settings",
                 items_sent, sb.checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d errors, %0d results missing", sb.errors, sb.pending_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/ltc_pkg.sv
sv/lru_tile_tag_cache_with_wash_core.sv
tb/sv/tb_lru_tile_tag_cache_with_wash_core.sv
